// ===== rtl/sawlc_pkg.sv =====
// Package for the stop-and-wait link controller: event and result codes,
// the result word type and register indexes. No dependencies.
`timescale 1ns / 1ps

package sawlc_pkg;

  typedef enum logic [1:0] {
    REQ_QUEUE = 2'd0,
    REQ_RX    = 2'd1,
    REQ_ACK   = 2'd2,
    REQ_TICK  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    OUT_ACK_SENT = 3'd0,
    OUT_NEW_MSG  = 3'd1,
    OUT_RESEND   = 3'd2,
    OUT_GAVE_UP  = 3'd3,
    OUT_RX_VERD  = 3'd4,
    OUT_Q_FULL   = 3'd5
  } out_kind_e;

  typedef struct packed {
    out_kind_e   kind;
    logic [3:0]  msg_kind;
    logic [15:0] frame_id;
    logic [63:0] payload;
    logic [3:0]  retry;
    logic        dup;
  } res_t;

  localparam logic [0:0] CFG_ACK_TIMEOUT = 1'b0;
  localparam logic [0:0] CFG_RETRY_LIMIT = 1'b1;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd10;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;

  localparam int unsigned MAX_RES = 3;

endpackage

// ===== rtl/stop_and_wait_link_control_core.sv =====
// Top level of the stop-and-wait link controller: input register, event logic,
// transmit queue memory and result buffer. Depends on sawlc_pkg.
`timescale 1ns / 1ps

// Usage:
// Events enter on the s_axis channel: tuser carries the event type (queue,
// data frame received, ack received, tick) and tdata the frame fields. Results
// leave on the m_axis channel with the result kind in tuser; tlast marks the
// final result word caused by one event. Configuration is to be written
// through cfg_we_i / cfg_idx_i / cfg_wdata_i only while the block is idle;
// the block itself does not enforce this. A word accepted on s_axis is held
// in the input register and evaluated from it once the result buffer can
// load; its results are registered into the three-entry result buffer. An
// event with k results occupies the buffer until all k are taken; the buffer
// sends one result word per cycle while m_axis_tready is high. The next event
// is evaluated in the cycle the last result of the previous one is taken.
// The transmit queue is a memory of QUEUE_DEPTH entries with a registered
// read port that always holds the current head entry.
// Reset clears all link state and loads the register defaults (timeout 10
// ticks, retry limit 3); no clearing pass is needed. When the receiver stalls,
// the result buffer holds, the input register fills and s_axis_tready drops.
module stop_and_wait_link_control_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // Event input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: msg_kind[3:0], frame_id[19:4], payload_word[83:20], slot_open[84]
  input  logic [87:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_msg_kind[3:0], out_frame_id[19:4], out_payload[83:20],
  //        retry_number[87:84], is_duplicate[88]
  output logic [95:0] m_axis_tdata,
  // tuser: out_kind[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import sawlc_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  // Configuration registers.
  logic [7:0] timeout_q;
  logic [3:0] retry_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= ACK_TIMEOUT_RST;
      retry_lim_q <= RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACK_TIMEOUT: timeout_q   <= cfg_wdata_i;
        CFG_RETRY_LIMIT: retry_lim_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic        in_vld_q, in_vld_d;
  req_e        in_req_q;
  logic [3:0]  in_mk_q;
  logic [15:0] in_id_q;
  logic [63:0] in_pay_q;
  logic        in_slot_q;
  logic        in_acc;
  logic        proc;

  // Result buffer.
  res_t       res_q [MAX_RES];
  logic [1:0] res_cnt_q, res_cnt_d;
  logic [1:0] res_rd_q, res_rd_d;
  logic       can_load;
  logic       out_acc;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (res_cnt_q != 2'd0);
  assign can_load      = !m_axis_tvalid || (m_axis_tready && (res_rd_q == res_cnt_q - 2'd1));
  assign proc          = in_vld_q && can_load;
  assign s_axis_tready = !in_vld_q || proc;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_req_q  <= req_e'(s_axis_tuser);
      in_mk_q   <= s_axis_tdata[3:0];
      in_id_q   <= s_axis_tdata[19:4];
      in_pay_q  <= s_axis_tdata[83:20];
      in_slot_q <= s_axis_tdata[84];
    end
  end

  // Link state.
  logic            ack_owed_q, ack_owed_d;
  logic [15:0]     ack_id_q, ack_id_d;
  logic [3:0]      ack_kind_q, ack_kind_d;
  logic            rx_seen_q, rx_seen_d;
  logic [15:0]     rx_last_q, rx_last_d;
  logic            awaiting_q, awaiting_d;
  logic [15:0]     out_id_q, out_id_d;
  logic [3:0]      out_kind_q, out_kind_d;
  logic [63:0]     out_pay_q, out_pay_d;
  logic [7:0]      ticks_q, ticks_d;
  logic [3:0]      resend_q, resend_d;
  logic [15:0]     next_id_q, next_id_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] fifo_cnt_q, fifo_cnt_d;

  // Transmit queue memory; the read register always tracks the head entry.
  logic [67:0]     fifo_mem [QUEUE_DEPTH];
  logic [67:0]     head_data_q;
  logic            fifo_we;
  logic [67:0]     fifo_wdata;

  res_t       new_res [MAX_RES];
  logic [1:0] new_n;

  always_comb begin
    logic       dup;
    logic [7:0] t_inc;
    logic       await_mid;
    ack_owed_d = ack_owed_q;
    ack_id_d   = ack_id_q;
    ack_kind_d = ack_kind_q;
    rx_seen_d  = rx_seen_q;
    rx_last_d  = rx_last_q;
    awaiting_d = awaiting_q;
    out_id_d   = out_id_q;
    out_kind_d = out_kind_q;
    out_pay_d  = out_pay_q;
    ticks_d    = ticks_q;
    resend_d   = resend_q;
    next_id_d  = next_id_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fifo_cnt_d = fifo_cnt_q;
    fifo_we    = 1'b0;
    fifo_wdata = {in_mk_q, in_pay_q};
    new_n      = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      new_res[i] = '0;
    end
    dup       = rx_seen_q && (in_id_q == rx_last_q);
    t_inc     = (ticks_q == 8'hFF) ? ticks_q : ticks_q + 8'd1;
    await_mid = awaiting_q;

    if (proc) begin
      case (in_req_q)
        REQ_QUEUE: begin
          if (fifo_cnt_q < DepthCnt) begin
            fifo_we    = 1'b1;
            tail_d     = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
            fifo_cnt_d = fifo_cnt_q + 1'b1;
          end else begin
            new_res[0].kind     = OUT_Q_FULL;
            new_res[0].msg_kind = in_mk_q;
            new_n               = 2'd1;
          end
        end
        REQ_RX: begin
          ack_owed_d = 1'b1;
          ack_id_d   = in_id_q;
          ack_kind_d = in_mk_q;
          if (!dup) begin
            rx_seen_d = 1'b1;
            rx_last_d = in_id_q;
          end
          new_res[0].kind     = OUT_RX_VERD;
          new_res[0].msg_kind = in_mk_q;
          new_res[0].frame_id = in_id_q;
          new_res[0].dup      = dup;
          new_n               = 2'd1;
        end
        REQ_ACK: begin
          if (awaiting_q && (out_id_q == in_id_q)) begin
            awaiting_d = 1'b0;
            resend_d   = 4'd0;
          end
        end
        default: begin
          ticks_d = t_inc;
          if (in_slot_q) begin
            if (ack_owed_q) begin
              new_res[new_n].kind     = OUT_ACK_SENT;
              new_res[new_n].msg_kind = ack_kind_q;
              new_res[new_n].frame_id = ack_id_q;
              new_n                   = new_n + 2'd1;
              ack_owed_d              = 1'b0;
            end
            if (awaiting_q && (t_inc >= timeout_q)) begin
              if (resend_q < retry_lim_q) begin
                resend_d                = resend_q + 4'd1;
                ticks_d                 = 8'd0;
                new_res[new_n].kind     = OUT_RESEND;
                new_res[new_n].msg_kind = out_kind_q;
                new_res[new_n].frame_id = out_id_q;
                new_res[new_n].payload  = out_pay_q;
                new_res[new_n].retry    = resend_q + 4'd1;
              end else begin
                await_mid               = 1'b0;
                resend_d                = 4'd0;
                new_res[new_n].kind     = OUT_GAVE_UP;
                new_res[new_n].msg_kind = out_kind_q;
                new_res[new_n].frame_id = out_id_q;
              end
              new_n = new_n + 2'd1;
            end
            awaiting_d = await_mid;
            // A new message goes out only when no ack is awaited.
            if (!await_mid && (fifo_cnt_q != '0)) begin
              out_kind_d              = head_data_q[67:64];
              out_pay_d               = head_data_q[63:0];
              head_d                  = (head_q == LastPtr) ? '0 : head_q + 1'b1;
              fifo_cnt_d              = fifo_cnt_q - 1'b1;
              out_id_d                = next_id_q;
              next_id_d               = next_id_q + 16'd1;
              awaiting_d              = 1'b1;
              ticks_d                 = 8'd0;
              resend_d                = 4'd0;
              new_res[new_n].kind     = OUT_NEW_MSG;
              new_res[new_n].msg_kind = head_data_q[67:64];
              new_res[new_n].frame_id = next_id_q;
              new_res[new_n].payload  = head_data_q[63:0];
              new_n                   = new_n + 2'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_owed_q <= 1'b0;
      ack_id_q   <= '0;
      ack_kind_q <= '0;
      rx_seen_q  <= 1'b0;
      rx_last_q  <= '0;
      awaiting_q <= 1'b0;
      out_id_q   <= '0;
      out_kind_q <= '0;
      out_pay_q  <= '0;
      ticks_q    <= '0;
      resend_q   <= '0;
      next_id_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      fifo_cnt_q <= '0;
    end else begin
      ack_owed_q <= ack_owed_d;
      ack_id_q   <= ack_id_d;
      ack_kind_q <= ack_kind_d;
      rx_seen_q  <= rx_seen_d;
      rx_last_q  <= rx_last_d;
      awaiting_q <= awaiting_d;
      out_id_q   <= out_id_d;
      out_kind_q <= out_kind_d;
      out_pay_q  <= out_pay_d;
      ticks_q    <= ticks_d;
      resend_q   <= resend_d;
      next_id_q  <= next_id_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  // Reading at the next head address with write forwarding keeps the read
  // register equal to the current head entry after every edge.
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[tail_q] <= fifo_wdata;
    end
    if (fifo_we && (tail_q == head_d)) begin
      head_data_q <= fifo_wdata;
    end else begin
      head_data_q <= fifo_mem[head_d];
    end
  end

  // Result buffer control.
  always_comb begin
    res_cnt_d = res_cnt_q;
    res_rd_d  = res_rd_q;
    if (proc) begin
      res_cnt_d = new_n;
      res_rd_d  = 2'd0;
    end else if (out_acc) begin
      if (res_rd_q == res_cnt_q - 2'd1) begin
        res_cnt_d = 2'd0;
        res_rd_d  = 2'd0;
      end else begin
        res_rd_d = res_rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
      res_rd_q  <= 2'd0;
    end else begin
      res_cnt_q <= res_cnt_d;
      res_rd_q  <= res_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_q[i] <= new_res[i];
      end
    end
  end

  res_t cur_res;
  assign cur_res      = res_q[res_rd_q];
  assign m_axis_tuser = cur_res.kind;
  assign m_axis_tlast = (res_rd_q == res_cnt_q - 2'd1);
  assign m_axis_tdata = {7'd0, cur_res.dup, cur_res.retry, cur_res.payload,
                         cur_res.frame_id, cur_res.msg_kind};

  // Assertions.
  a_res_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_q != 2'd0) |-> (res_rd_q < res_cnt_q))
    else $error("result read index beyond stored results");

  a_fifo_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= DepthCnt)
    else $error("transmit queue count above depth");

  a_fifo_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt_q == '0) |-> (head_q == tail_q))
    else $error("empty transmit queue with unequal pointers");

  a_await_from_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !awaiting_q ##1 awaiting_q |-> $past(proc && (in_req_q == REQ_TICK) && in_slot_q))
    else $error("ack wait started without a send on an open slot");

endmodule

// ===== tb/sawlc_link_checker.sv =====
// Checker for the stop-and-wait link controller: watches the event, result and
// configuration ports, predicts every result word and compares. Uses sawlc_pkg.
`timescale 1ns / 1ps

module sawlc_link_checker #(
  parameter int unsigned QDEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [87:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [95:0] m_tdata_i,
  input  logic [2:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);
  import sawlc_pkg::*;

  typedef struct packed {
    out_kind_e   kind;
    logic [3:0]  msg_kind;
    logic [15:0] frame_id;
    logic [63:0] payload;
    logic [3:0]  retry;
    logic        dup;
    logic        last;
  } link_word_t;

  link_word_t expected_words[$];
  link_word_t act_word;
  link_word_t exp_word;

  logic [7:0]  timeout_cfg;
  logic [3:0]  retry_cfg;
  logic        owe_ack;
  logic [15:0] owed_id;
  logic [3:0]  owed_kind;
  logic        rx_valid;
  logic [15:0] rx_prev_id;
  logic        tx_pending;
  logic [15:0] tx_id;
  logic [3:0]  tx_kind;
  logic [63:0] tx_payload;
  logic [7:0]  tick_age;
  logic [3:0]  resend_cnt;
  logic [15:0] id_counter;
  logic [3:0]  q_kind [QDEPTH];
  logic [63:0] q_payload [QDEPTH];
  int          q_head;
  int          q_tail;
  int          q_count;

  // Works out the result words of one accepted event and advances the link state.
  task automatic predict_event(input req_e req, input logic [3:0] mk, input logic [15:0] id,
                               input logic [63:0] pay, input logic slot);
    link_word_t batch [3];
    int n;
    logic dup;
    n = 0;
    case (req)
      REQ_QUEUE: begin
        if (q_count < QDEPTH) begin
          q_kind[q_tail]    = mk;
          q_payload[q_tail] = pay;
          q_tail  = (q_tail + 1) % QDEPTH;
          q_count = q_count + 1;
        end else begin
          batch[n] = '{OUT_Q_FULL, mk, 16'h0, 64'h0, 4'h0, 1'b0, 1'b0};
          n++;
        end
      end
      REQ_RX: begin
        dup       = rx_valid && (id == rx_prev_id);
        owe_ack   = 1'b1;
        owed_id   = id;
        owed_kind = mk;
        if (!dup) begin
          rx_valid   = 1'b1;
          rx_prev_id = id;
        end
        batch[n] = '{OUT_RX_VERD, mk, id, 64'h0, 4'h0, dup, 1'b0};
        n++;
      end
      REQ_ACK: begin
        if (tx_pending && tx_id == id) begin
          tx_pending = 1'b0;
          resend_cnt = 4'h0;
        end
      end
      default: begin
        if (tick_age != 8'hFF) tick_age = tick_age + 8'd1;
        if (slot) begin
          if (owe_ack) begin
            batch[n] = '{OUT_ACK_SENT, owed_kind, owed_id, 64'h0, 4'h0, 1'b0, 1'b0};
            n++;
            owe_ack = 1'b0;
          end
          if (tx_pending && tick_age >= timeout_cfg) begin
            if (resend_cnt < retry_cfg) begin
              resend_cnt = resend_cnt + 4'd1;
              tick_age   = 8'h0;
              batch[n] = '{OUT_RESEND, tx_kind, tx_id, tx_payload, resend_cnt, 1'b0, 1'b0};
              n++;
            end else begin
              tx_pending = 1'b0;
              resend_cnt = 4'h0;
              batch[n] = '{OUT_GAVE_UP, tx_kind, tx_id, 64'h0, 4'h0, 1'b0, 1'b0};
              n++;
            end
          end
          // A frame given up in this tick leaves room for the next queued message.
          if (!tx_pending && q_count > 0) begin
            tx_kind     = q_kind[q_head];
            tx_payload  = q_payload[q_head];
            q_head      = (q_head + 1) % QDEPTH;
            q_count     = q_count - 1;
            tx_id       = id_counter;
            id_counter  = id_counter + 16'd1;
            tx_pending  = 1'b1;
            tick_age    = 8'h0;
            resend_cnt  = 4'h0;
            batch[n] = '{OUT_NEW_MSG, tx_kind, tx_id, tx_payload, 4'h0, 1'b0, 1'b0};
            n++;
          end
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) batch[i].last = 1'b1;
      expected_words.push_back(batch[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_cfg      = ACK_TIMEOUT_RST;
      retry_cfg        = RETRY_LIMIT_RST;
      owe_ack          = 1'b0;
      owed_id          = 16'h0;
      owed_kind        = 4'h0;
      rx_valid         = 1'b0;
      rx_prev_id       = 16'h0;
      tx_pending       = 1'b0;
      tx_id            = 16'h0;
      tx_kind          = 4'h0;
      tx_payload       = 64'h0;
      tick_age         = 8'h0;
      resend_cnt       = 4'h0;
      id_counter       = 16'h0;
      q_head           = 0;
      q_tail           = 0;
      q_count          = 0;
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACK_TIMEOUT: timeout_cfg = cfg_wdata_i;
          CFG_RETRY_LIMIT: retry_cfg   = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_event(req_e'(s_tuser_i), s_tdata_i[3:0], s_tdata_i[19:4],
                      s_tdata_i[83:20], s_tdata_i[84]);
      end
      if (m_tvalid_i && m_tready_i) begin
        act_word = '{out_kind_e'(m_tuser_i), m_tdata_i[3:0], m_tdata_i[19:4],
                     m_tdata_i[83:20], m_tdata_i[87:84], m_tdata_i[88], m_tlast_i};
        if (expected_words.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("unexpected result word: kind %0d id %h", m_tuser_i, m_tdata_i[19:4]);
        end else begin
          exp_word = expected_words.pop_front();
          if (exp_word.kind !== act_word.kind || exp_word.msg_kind !== act_word.msg_kind ||
              exp_word.frame_id !== act_word.frame_id ||
              exp_word.payload !== act_word.payload || exp_word.retry !== act_word.retry ||
              exp_word.dup !== act_word.dup || exp_word.last !== act_word.last) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("mismatch (expected/actual): kind %0d/%0d msg_kind %h/%h id %h/%h",
                       exp_word.kind, act_word.kind, exp_word.msg_kind, act_word.msg_kind,
                       exp_word.frame_id, act_word.frame_id);
              $display("  payload %h/%h retry %0d/%0d dup %b/%b last %b/%b",
                       exp_word.payload, act_word.payload, exp_word.retry, act_word.retry,
                       exp_word.dup, act_word.dup, exp_word.last, act_word.last);
            end
          end
        end
      end
      pending_count_o = expected_words.size();
    end
  end

endmodule

// ===== tb/stop_and_wait_link_control_core_tb.sv =====
// Testbench top for the stop-and-wait link controller: clock, reset, event and
// configuration stimulus, receiver stalls and verdict. Uses sawlc_pkg and sawlc_link_checker.
`timescale 1ns / 1ps

module stop_and_wait_link_control_core_tb;
  import sawlc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = CFG_ACK_TIMEOUT;
  logic [7:0]  cfg_wdata_i = 8'h0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = REQ_QUEUE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          mismatch_count;
  int          pending_count;
  int          snd_idle_pct = 17;
  int          rcv_idle_pct = 66;
  logic        hold_rx = 1'b0;
  logic        pressure_req = 1'b0;
  logic [15:0] last_tx_id = 16'h0;

  logic [7:0]  phase_timeout [6] = '{8'd1, 8'd255, 8'd0, 8'd4, 8'd10, 8'd2};
  logic [3:0]  phase_retry   [6] = '{4'd15, 4'd0, 4'd0, 4'd2, 4'd3, 4'd1};

  stop_and_wait_link_control_core #(
    .QUEUE_DEPTH(16)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sawlc_link_checker #(
    .QDEPTH(16)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .m_tlast_i        (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= hold_rx ? 1'b0 : ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Long receiver hold-off while the sender keeps offering words.
  always begin
    wait (pressure_req);
    hold_rx <= 1'b1;
    repeat (200) @(posedge clk_i);
    hold_rx <= 1'b0;
    pressure_req = 1'b0;
  end

  // Ids of frames on the air, so that most acks match the outstanding message.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready &&
        (m_axis_tuser == OUT_NEW_MSG || m_axis_tuser == OUT_RESEND))
      last_tx_id <= m_axis_tdata[19:4];
  end

  task automatic send_event(input req_e req, input logic [3:0] mk, input logic [15:0] id,
                            input logic [63:0] pay, input logic slot);
    logic ready_seen;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, slot, pay, id, mk};
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready;
      @(posedge clk_i);
    end while (!ready_seen);
  endtask

  // Stops offering events and waits until every expected word has arrived.
  task automatic drain_link();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] timeout_val, input logic [3:0] retry_val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ACK_TIMEOUT;
    cfg_wdata_i <= timeout_val;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RETRY_LIMIT;
    cfg_wdata_i <= {4'($urandom), retry_val};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [63:0] pick_payload();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '1;
    if (sel == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  task automatic random_event();
    int sel;
    int idsel;
    logic [15:0] id;
    sel = $urandom_range(0, 99);
    if (sel < 22) begin
      send_event(REQ_QUEUE, 4'($urandom), 16'($urandom), pick_payload(), 1'($urandom));
    end else if (sel < 40) begin
      // Small ids make duplicate frames common.
      idsel = $urandom_range(0, 9);
      id = (idsel < 6) ? 16'($urandom_range(0, 3)) : (idsel < 8) ? 16'hFFFF : 16'($urandom);
      send_event(REQ_RX, 4'($urandom), id, {$urandom, $urandom}, 1'($urandom));
    end else if (sel < 60) begin
      idsel = $urandom_range(0, 99);
      id = (idsel < 70) ? last_tx_id : (idsel < 85) ? last_tx_id - 16'd1 : 16'($urandom);
      send_event(REQ_ACK, 4'($urandom), id, {$urandom, $urandom}, 1'($urandom));
    end else begin
      send_event(REQ_TICK, 4'($urandom), 16'($urandom), {$urandom, $urandom},
                 $urandom_range(0, 99) < 80);
    end
  endtask

  initial begin
    int count;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: duplicate detection, owed ack, new message and ack matching.
    send_event(REQ_RX,    4'h0, 16'h0000, 64'h0, 1'b0);
    send_event(REQ_RX,    4'hF, 16'h0000, 64'h0, 1'b0);
    send_event(REQ_RX,    4'h5, 16'hFFFF, 64'h0, 1'b1);
    send_event(REQ_ACK,   4'h0, 16'h0000, 64'h0, 1'b0);
    send_event(REQ_TICK,  4'h0, 16'h0000, 64'h0, 1'b0);
    send_event(REQ_TICK,  4'h0, 16'h0000, 64'h0, 1'b1);
    send_event(REQ_QUEUE, 4'hF, 16'hFFFF, '1,    1'b1);
    send_event(REQ_QUEUE, 4'h0, 16'h0000, 64'h0, 1'b0);
    send_event(REQ_RX,    4'h3, 16'h1234, 64'h0, 1'b0);
    send_event(REQ_TICK,  4'h0, 16'h0000, 64'h0, 1'b1);
    send_event(REQ_ACK,   4'h0, 16'h0001, 64'h0, 1'b0);
    send_event(REQ_ACK,   4'h0, 16'h0000, 64'h0, 1'b0);
    send_event(REQ_TICK,  4'h0, 16'h0000, 64'h0, 1'b1);
    drain_link();

    // Short timeout and one retry: resend, give up with a new message in the same tick.
    write_config(8'd1, 4'd1);
    send_event(REQ_QUEUE, 4'h3, 16'h0000, {$urandom, $urandom}, 1'b0);
    send_event(REQ_QUEUE, 4'h9, 16'h0000, {$urandom, $urandom}, 1'b0);
    send_event(REQ_RX,    4'h2, 16'h0007, 64'h0, 1'b0);
    send_event(REQ_TICK,  4'h0, 16'h0000, 64'h0, 1'b1);
    send_event(REQ_RX,    4'h2, 16'h0007, 64'h0, 1'b0);
    send_event(REQ_TICK,  4'h0, 16'h0000, 64'h0, 1'b1);
    send_event(REQ_TICK,  4'h0, 16'h0000, 64'h0, 1'b1);
    send_event(REQ_ACK,   4'h0, 16'h0002, 64'h0, 1'b0);
    send_event(REQ_TICK,  4'h0, 16'h0000, 64'h0, 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain_link();
      snd_idle_pct = (p < 2) ? 17 : (p < 4) ? 66 : 0;
      rcv_idle_pct = (p < 2) ? 66 : (p < 4) ? 17 : 0;
      write_config(phase_timeout[p], phase_retry[p]);
      if (p == 4) pressure_req = 1'b1;
      count = 0;
      while (count < 58) begin
        if ($urandom_range(0, 99) < 3) begin
          // A burst of messages overruns the transmit queue.
          repeat (17) send_event(REQ_QUEUE, 4'($urandom), 16'($urandom), pick_payload(),
                                 1'($urandom));
          count += 17;
        end else begin
          random_event();
          count++;
        end
      end
    end

    drain_link();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sawlc_pkg.sv
rtl/stop_and_wait_link_control_core.sv
tb/sawlc_link_checker.sv
tb/stop_and_wait_link_control_core_tb.sv
